/* hw/rtl/mco_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mco_pkg
// Shared types, widths and constants of the midpoint circle outline block.
// ----------------------------------------------------------------------------
package mco_pkg;

  // Field widths of the ports.
  localparam int IDX_W = 20;
  localparam int DIM_W = 11;
  localparam int RAD_W = 3;
  localparam int CFG_IDX_W = 2;

  // Field limits.
  localparam logic [DIM_W-1:0] MAX_WIDTH  = 11'd1024;
  localparam logic [DIM_W-1:0] MAX_HEIGHT = 11'd1024;
  localparam logic [RAD_W-1:0] MAX_RADIUS = 3'd7;

  // An in-field row is below MAX_HEIGHT, so this many bits feed the multiplier.
  localparam int ROW_MUL_W = 10;

  // Divider: one quotient bit per cycle.
  localparam int DIV_STEPS = IDX_W;
  localparam int DIV_CNT_W = 5;

  // Circle loop: small coordinates and decision variable.
  localparam int XY_W = 4;
  localparam int DEC_W = 8;
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] MAX_STEPS = 3'd6;

  // Signed coordinate widths of a generated point.
  localparam int COL_W = DIM_W + 1;
  localparam int ROW_W = IDX_W + 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIELD_WIDTH  = 2'd0,
    CFG_FIELD_HEIGHT = 2'd1,
    CFG_CIRCLE_RADIUS = 2'd2
  } cfg_idx_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } mco_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic emit;
  } mco_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_done;
    logic last_point;
  } mco_sts_t;

  // Zero maps to one and values above the maximum saturate.
  function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > maxv) begin
      res = maxv;
    end
    return res;
  endfunction

endpackage

/* hw/rtl/midpoint_circle_outline.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_outline
// Splits a centre cell index into column and row, then walks the midpoint
// circle loop and emits eight mirrored outline points per loop step.
//
// Channel  Ports                                      Handshake
// input    start, busy, in_center_index               start && !busy
// result   out_valid, out_point_index,                one-cycle strobe
//          out_in_field, out_last
// config   cfg_valid, cfg_ready, cfg_index, cfg_wdata cfg_valid && cfg_ready
//
// From one accept to the next, an item passes the accept in the idle state,
// the busy divide phase in the serial divider, then the busy emit phase of n
// loop steps (1 to 6) with one point per cycle. Results trail the generator
// by two pipeline stages. Reset is synchronous and active low and restores
// width 256, height 256 and radius 5. The result side cannot stall; every
// point is presented for exactly one cycle.
// ----------------------------------------------------------------------------
module midpoint_circle_outline
  import mco_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [IDX_W-1:0]     in_center_index,
  output logic                 out_valid,
  output logic [IDX_W-1:0]     out_point_index,
  output logic                 out_in_field,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata
);

  // Configuration registers; indexes beyond the list are dropped.
  logic [DIM_W-1:0] field_width_r, field_height_r;
  logic [RAD_W-1:0] circle_radius_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_width_r   <= DIM_W'(256);
      field_height_r  <= DIM_W'(256);
      circle_radius_r <= RAD_W'(5);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FIELD_WIDTH:   field_width_r   <= cfg_wdata;
        CFG_FIELD_HEIGHT:  field_height_r  <= cfg_wdata;
        CFG_CIRCLE_RADIUS: circle_radius_r <= cfg_wdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective field size and radius.
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [RAD_W-1:0] r_eff;

  assign w_eff = clamp_size(field_width_r, MAX_WIDTH);
  assign h_eff = clamp_size(field_height_r, MAX_HEIGHT);
  assign r_eff = (circle_radius_r > MAX_RADIUS) ? MAX_RADIUS : circle_radius_r;

  mco_cmd_t cmd;
  mco_sts_t sts;

  mco_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  mco_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .center_index    (in_center_index),
    .w_eff           (w_eff),
    .h_eff           (h_eff),
    .radius          (r_eff),
    .out_valid       (out_valid),
    .out_point_index (out_point_index),
    .out_in_field    (out_in_field),
    .out_last        (out_last)
  );

`ifndef SYNTH
  // An accepted centre keeps the block busy for the divide phase.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted centre");

  // The final point of a run is never followed directly by another result.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result strobe directly after the last point");

  // Clipped points carry index zero.
  a_clipped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_field |-> out_point_index == '0)
    else $error("clipped point with nonzero index");

  // No result appears once the block has stayed idle long enough to drain both point stages.
  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && $past(!busy) && $past(!busy, 2) |-> !out_valid)
    else $error("result strobe without an item in flight");
`endif

endmodule

/* hw/rtl/mco_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mco_ctrl
// Sequencer: accepts a centre, runs the divider, then steps the outline loop.
// ----------------------------------------------------------------------------
module mco_ctrl
  import mco_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  mco_sts_t sts,
  output mco_cmd_t cmd,
  output logic     busy
);

  mco_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.last_point) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

/* hw/rtl/mco_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mco_datapath
// Serial divider for the centre, midpoint loop registers and a two-stage
// point pipeline that produces index and in-field flag.
// ----------------------------------------------------------------------------
module mco_datapath
  import mco_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  mco_cmd_t         cmd,
  output mco_sts_t         sts,
  input  logic [IDX_W-1:0] center_index,
  input  logic [DIM_W-1:0] w_eff,
  input  logic [DIM_W-1:0] h_eff,
  input  logic [RAD_W-1:0] radius,
  output logic             out_valid,
  output logic [IDX_W-1:0] out_point_index,
  output logic             out_in_field,
  output logic             out_last
);

  // --------------------------------------------------------------------------
  // Restoring divider: quo_r shifts the dividend out and the quotient in.
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]     quo_r;
  logic [DIM_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [DIM_W:0]       trial;
  logic [DIM_W:0]       diff;
  logic                 ge;

  assign trial = {rem_r, quo_r[IDX_W-1]};
  assign diff  = trial - {1'b0, w_eff};
  assign ge    = trial >= {1'b0, w_eff};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r     <= center_index;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r     <= {quo_r[IDX_W-2:0], ge};
      rem_r     <= ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  assign sts.div_done = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  // --------------------------------------------------------------------------
  // Midpoint loop registers, advanced after the eighth point of a step.
  // --------------------------------------------------------------------------
  logic [XY_W-1:0]          x_r, y_r, x_nxt, y_nxt;
  logic signed [DEC_W-1:0]  d_r, d_nxt;
  logic [STEP_W-1:0]        steps_r;
  logic [2:0]               pt_r;
  logic                     more;
  logic signed [DEC_W-1:0]  x_s, y_s;

  assign x_s = DEC_W'(x_r);
  assign y_s = DEC_W'(y_r);

  always_comb begin
    x_nxt = x_r + XY_W'(1);
    if (d_r < 0) begin
      d_nxt = d_r + (x_s <<< 2) + DEC_W'(6);
      y_nxt = y_r;
    end else begin
      d_nxt = d_r + ((x_s - y_s) <<< 2) + DEC_W'(10);
      y_nxt = y_r - XY_W'(1);
    end
  end

  // Once Y has reached zero the next X already passes it, so the loop ends
  // there; this also keeps a wrapped Y from extending the run.
  assign more = (y_r != '0) && (x_nxt <= y_nxt) &&
                ((steps_r + STEP_W'(1)) < MAX_STEPS);
  assign sts.last_point = (pt_r == 3'd7) && !more;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= '0;
      y_r     <= XY_W'(radius);
      d_r     <= DEC_W'(3) - (DEC_W'(radius) <<< 1);
      steps_r <= '0;
      pt_r    <= '0;
    end else if (cmd.emit) begin
      pt_r <= pt_r + 3'd1;
      if (pt_r == 3'd7) begin
        x_r     <= x_nxt;
        y_r     <= y_nxt;
        d_r     <= d_nxt;
        steps_r <= steps_r + STEP_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Point stage A: mirrored coordinates. Bit 2 of the point number picks the
  // column sign, bit 1 the row sign and bit 0 swaps the two offsets.
  // --------------------------------------------------------------------------
  logic [XY_W-1:0]         off_col, off_row;
  logic signed [COL_W-1:0] col_nxt, col_r;
  logic signed [ROW_W-1:0] row_nxt, row_r;
  logic                    v1_r, last1_r;

  assign off_col = pt_r[0] ? y_r : x_r;
  assign off_row = pt_r[0] ? x_r : y_r;

  always_comb begin
    if (pt_r[2]) begin
      col_nxt = {1'b0, rem_r} + COL_W'(off_col);
    end else begin
      col_nxt = {1'b0, rem_r} - COL_W'(off_col);
    end
    if (pt_r[1]) begin
      row_nxt = {2'b00, quo_r} + ROW_W'(off_row);
    end else begin
      row_nxt = {2'b00, quo_r} - ROW_W'(off_row);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    last1_r <= sts.last_point;
  end

  // --------------------------------------------------------------------------
  // Point stage B: clipping and linear index row * width + column.
  // --------------------------------------------------------------------------
  logic               pt_in_field;
  logic [IDX_W:0]     prod;
  logic [IDX_W:0]     sum;
  logic               out_valid_r, out_in_field_r, out_last_r;
  logic [IDX_W-1:0]   out_point_index_r;

  assign pt_in_field = !col_r[COL_W-1] && (col_r[DIM_W-1:0] < w_eff) &&
                       !row_r[ROW_W-1] && (row_r[ROW_W-2:0] < (ROW_W-1)'(h_eff));
  assign prod   = (IDX_W+1)'(row_r[ROW_MUL_W-1:0]) * (IDX_W+1)'(w_eff);
  assign sum    = prod + (IDX_W+1)'(col_r[DIM_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    out_in_field_r    <= pt_in_field;
    out_point_index_r <= pt_in_field ? sum[IDX_W-1:0] : '0;
    out_last_r        <= last1_r;
  end

  assign out_valid       = out_valid_r;
  assign out_point_index = out_point_index_r;
  assign out_in_field    = out_in_field_r;
  assign out_last        = out_last_r;

endmodule

/* tb/mco_outline_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mco_outline_checker
// Watches the center, point and register channels of the midpoint circle
// outline block. It keeps its own copy of the field size and radius and
// computes the outline points that each accepted center must produce. Every
// point beat is then compared, field by field, with the oldest point still due.
// ----------------------------------------------------------------------------
module mco_outline_checker
  import mco_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [IDX_W-1:0]     in_center_index,
  input  logic                 out_valid,
  input  logic [IDX_W-1:0]     out_point_index,
  input  logic                 out_in_field,
  input  logic                 out_last,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata,
  output int                   mismatch_count,
  output int                   points_pending,
  output int                   centers_seen,
  output int                   points_checked
);

  // Only the first few failures are printed; the rest are still counted.
  localparam int REPORT_CAP = 40;
  localparam int MAX_POINTS = 48;
  localparam int STEP_POINTS = 8;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             in_fld;
    logic             last_pt;
  } outline_point_t;

  // Shadow copy of the register file.
  logic [DIM_W-1:0] fld_width;
  logic [DIM_W-1:0] fld_height;
  logic [RAD_W-1:0] radius;

  // Outline points predicted but not yet seen on the point channel.
  outline_point_t points_due[$];

  // One outline point, clipped against the field.
  function automatic outline_point_t outline_point(input int col, input int row,
                                                   input int w, input int h);
    outline_point_t pt;
    pt.in_fld = (col >= 0) && (col < w) && (row >= 0) && (row < h);
    pt.idx = pt.in_fld ? IDX_W'(row * w + col) : '0;
    pt.last_pt = 1'b0;
    return pt;
  endfunction

  // Walk the midpoint decision loop and queue the eight mirrored points of
  // every step. The final point of the center carries the last mark.
  task automatic predict_outline(input logic [IDX_W-1:0] center);
    int w;
    int h;
    int xc;
    int yc;
    int x;
    int y;
    int d;
    int n;
    outline_point_t pts[MAX_POINTS];
    // A zero size counts as one cell; oversize values saturate.
    w = (fld_width == '0) ? 1 :
        ((fld_width > MAX_WIDTH) ? int'(MAX_WIDTH) : int'(fld_width));
    h = (fld_height == '0) ? 1 :
        ((fld_height > MAX_HEIGHT) ? int'(MAX_HEIGHT) : int'(fld_height));
    xc = int'(center) % w;
    yc = int'(center) / w;
    x = 0;
    y = int'(radius);
    d = 3 - 2 * y;
    n = 0;
    while (x <= y && n + STEP_POINTS <= MAX_POINTS) begin
      for (int i = -1; i <= 1; i += 2) begin
        for (int j = -1; j <= 1; j += 2) begin
          pts[n]     = outline_point(xc + i * x, yc + j * y, w, h);
          pts[n + 1] = outline_point(xc + i * y, yc + j * x, w, h);
          n += 2;
        end
      end
      if (d < 0) begin
        d = d + 4 * x + 6;
      end else begin
        d = d + 4 * (x - y) + 10;
        y--;
      end
      x++;
    end
    pts[n - 1].last_pt = 1'b1;
    for (int k = 0; k < n; k++) begin
      points_due.insert(points_due.size(), pts[k]);
    end
    centers_seen++;
  endtask

  task automatic flag_mismatch(input string field, input logic [IDX_W-1:0] want,
                               input logic [IDX_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
    end
  endtask

  always @(posedge clk) begin
    outline_point_t exp_pt;
    if (!rst_n) begin
      fld_width = DIM_W'(256);
      fld_height = DIM_W'(256);
      radius = RAD_W'(5);
      points_due.delete();
    end else begin
      // Point beat: compare against the oldest point still due.
      if (out_valid) begin
        if (points_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP) begin
            $error("point beat with nothing due: point_index %0d", out_point_index);
          end
        end else begin
          exp_pt = points_due.pop_front();
          points_checked++;
          if (out_point_index !== exp_pt.idx) begin
            flag_mismatch("point_index", exp_pt.idx, out_point_index);
          end
          if (out_in_field !== exp_pt.in_fld) begin
            flag_mismatch("in_field", IDX_W'(exp_pt.in_fld), IDX_W'(out_in_field));
          end
          if (out_last !== exp_pt.last_pt) begin
            flag_mismatch("last", IDX_W'(exp_pt.last_pt), IDX_W'(out_last));
          end
        end
      end
      // Register beat: unknown indexes leave the registers alone.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FIELD_WIDTH: begin
            fld_width = cfg_wdata;
          end
          CFG_FIELD_HEIGHT: begin
            fld_height = cfg_wdata;
          end
          CFG_CIRCLE_RADIUS: begin
            radius = cfg_wdata[RAD_W-1:0];
          end
          default: begin
          end
        endcase
      end
      // Center beat.
      if (start && !busy) begin
        predict_outline(in_center_index);
      end
    end
    points_pending = points_due.size();
  end

endmodule

/* tb/midpoint_circle_outline_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_outline_tb
// Drives centers and register writes into the midpoint circle outline block.
// A directed part covers field corners and edges, far-off rows, radius zero,
// a one-cell field and saturated sizes; random phases then mix field sizes,
// radii and sender gaps. The checker beside the block predicts every point.
// ----------------------------------------------------------------------------
module midpoint_circle_outline_tb;
  import mco_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [IDX_W-1:0]     in_center_index = '0;
  logic                 out_valid;
  logic [IDX_W-1:0]     out_point_index;
  logic                 out_in_field;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_wdata = '0;

  int mismatch_count;
  int points_pending;
  int centers_seen;
  int points_checked;
  int cycle_cnt = 0;
  int settings_cnt = 0;

  // Effective field size, used only to aim centers at interesting cells.
  int stim_w = 256;
  int stim_h = 256;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  midpoint_circle_outline i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_center_index (in_center_index),
    .out_valid       (out_valid),
    .out_point_index (out_point_index),
    .out_in_field    (out_in_field),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  mco_outline_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_center_index (in_center_index),
    .out_valid       (out_valid),
    .out_point_index (out_point_index),
    .out_in_field    (out_in_field),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .points_pending  (points_pending),
    .centers_seen    (centers_seen),
    .points_checked  (points_checked)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One register beat.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drain the block, then load a new field size and radius. The radius write
  // carries junk in the upper data bits, and the spare index gets a write too.
  task automatic apply_setting(input int w, input int h, input int r);
    @(negedge clk);
    start <= 1'b0;
    while (points_pending != 0 || busy) @(negedge clk);
    write_reg(CFG_FIELD_WIDTH, DIM_W'(w));
    write_reg(CFG_FIELD_HEIGHT, DIM_W'(h));
    write_reg(CFG_CIRCLE_RADIUS, DIM_W'(r) | DIM_W'($urandom_range(255, 0) << RAD_W));
    write_reg(CFG_SPARE_IDX, DIM_W'($urandom));
    stim_w = (w == 0) ? 1 : ((w > int'(MAX_WIDTH)) ? int'(MAX_WIDTH) : w);
    stim_h = (h == 0) ? 1 : ((h > int'(MAX_HEIGHT)) ? int'(MAX_HEIGHT) : h);
    settings_cnt++;
  endtask

  // One center beat, after a random gap in which the data lines carry noise.
  task automatic push_center(input logic [IDX_W-1:0] center, input int idle_pct);
    while ($urandom_range(99, 0) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      in_center_index <= IDX_W'($urandom);
    end
    @(negedge clk);
    start <= 1'b1;
    in_center_index <= center;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Mostly centers inside or just past the field, often hugging an edge;
  // the rest spread over the whole index range.
  function automatic logic [IDX_W-1:0] pick_center();
    int col;
    int row;
    if ($urandom_range(99, 0) < 25) begin
      return IDX_W'($urandom);
    end
    col = $urandom_range(stim_w - 1, 0);
    row = $urandom_range(stim_h + 7, 0);
    if ($urandom_range(2, 0) == 0) begin
      col = $urandom_range(1, 0) ? ($urandom_range(7, 0) % stim_w)
                                 : (stim_w - 1 - ($urandom_range(7, 0) % stim_w));
    end
    if ($urandom_range(2, 0) == 0) begin
      row = $urandom_range(1, 0) ? $urandom_range(7, 0) : (stim_h - 4 + $urandom_range(7, 0));
    end
    return IDX_W'(row * stim_w + col);
  endfunction

  task automatic random_phase(input int w, input int h, input int r, input int idle_pct,
                              input int count);
    apply_setting(w, h, r);
    repeat (count) push_center(pick_center(), idle_pct);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values: corners, edges, middle and a row far below the field.
    push_center(IDX_W'(0), 0);
    push_center(IDX_W'(128 * 256 + 128), 0);
    push_center(IDX_W'(255), 0);
    push_center(IDX_W'(255 * 256), 0);
    push_center(IDX_W'(256 * 256 - 1), 0);
    push_center(IDX_W'(5 * 256 + 5), 0);
    push_center({IDX_W{1'b1}}, 0);

    // Radius zero: eight copies of the center.
    apply_setting(256, 256, 0);
    push_center(IDX_W'(0), 0);
    push_center(IDX_W'(100 * 256 + 37), 0);

    // Zero sizes act as a single cell.
    apply_setting(0, 0, 1);
    push_center(IDX_W'(0), 0);
    push_center(IDX_W'(3), 0);

    // Oversize values saturate; largest radius.
    apply_setting(2047, 2047, 7);
    push_center(IDX_W'(0), 0);
    push_center(IDX_W'(1023), 0);
    push_center(IDX_W'(1023 * 1024 + 1023), 0);
    push_center(IDX_W'(512 * 1024 + 512), 0);
    push_center({IDX_W{1'b1}}, 0);

    // Single row, one column past the maximum written.
    apply_setting(1025, 1, 3);
    push_center(IDX_W'(0), 0);
    push_center(IDX_W'(500), 0);
    push_center(IDX_W'(1024 + 500), 0);

    // Random phases with different settings and sender gaps.
    random_phase(256, 256, 5, 0, 50);
    random_phase(1024, 1024, 7, 77, 50);
    random_phase(0, 0, 3, 0, 25);
    random_phase(2047, 300, 6, 17, 50);
    random_phase(37, 1024, 2, 77, 40);
    random_phase(1, 2047, 0, 17, 25);
    random_phase(640, 480, 4, 0, 50);

    // Let every outstanding point come back, then a short quiet tail.
    @(negedge clk);
    start <= 1'b0;
    while (points_pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d outline points from %0d centers under %0d register settings.",
             points_checked, centers_seen, settings_cnt + 1);
    $display("Sizes from zero to past the maximum, radius 0 to 7, sender gaps 0/17/77%%.");
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
